FILE: sv/adc_sfr_pkg.sv
// Shared constants, types and helper functions of the ADC serial frame responder.
package adc_sfr_pkg;

    // Frame and channel geometry.
    localparam int FRAME_BYTES = 7;
    localparam int CHANNELS    = 4;
    localparam int POS_W       = 3;
    localparam int CH_W        = 2;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int CMD_W    = 6;
    localparam int ADDR_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_READ_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SLOT_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SLOT_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SLOT_C   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SLOT_D   = 3'd4;

    // Item operation codes.
    localparam logic OP_SERIAL = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Channels selected by the four address slots.
    localparam logic [CH_W-1:0] SLOT_A_CH = 2'd1;
    localparam logic [CH_W-1:0] SLOT_B_CH = 2'd2;
    localparam logic [CH_W-1:0] SLOT_C_CH = 2'd3;
    localparam logic [CH_W-1:0] SLOT_D_CH = 2'd0;

    // Reset values of the address slots.
    localparam logic [ADDR_W-1:0] SLOT_A_RST = 9'd0;
    localparam logic [ADDR_W-1:0] SLOT_B_RST = 9'd1;
    localparam logic [ADDR_W-1:0] SLOT_C_RST = 9'd2;
    localparam logic [ADDR_W-1:0] SLOT_D_RST = 9'd3;

    // Configuration values handed to the frame logic.
    typedef struct packed {
        logic [CMD_W-1:0]  ram_read_code;
        logic [ADDR_W-1:0] addr_slot_a;
        logic [ADDR_W-1:0] addr_slot_b;
        logic [ADDR_W-1:0] addr_slot_c;
        logic [ADDR_W-1:0] addr_slot_d;
    } t_cfg;

    // Reverse the bit order of one byte.
    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

FILE: sv/adc_sfr_samples.sv
// Per-channel voltage and current sample storage with one write and one read port.
module adc_sfr_samples (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [adc_sfr_pkg::CH_W-1:0]          i_wr_ch,
    input  logic [adc_sfr_pkg::SAMPLE_W-1:0]      i_wr_voltage,
    input  logic [adc_sfr_pkg::SAMPLE_W-1:0]      i_wr_current,
    input  logic [adc_sfr_pkg::CH_W-1:0]          i_rd_ch,
    output logic [adc_sfr_pkg::SAMPLE_W-1:0]      o_rd_voltage,
    output logic [adc_sfr_pkg::SAMPLE_W-1:0]      o_rd_current
);

    logic [adc_sfr_pkg::SAMPLE_W-1:0] r_voltage [adc_sfr_pkg::CHANNELS];
    logic [adc_sfr_pkg::SAMPLE_W-1:0] r_current [adc_sfr_pkg::CHANNELS];

    // Sample writes; both stores start at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < adc_sfr_pkg::CHANNELS; i++) begin
                r_voltage[i] <= '0;
                r_current[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_voltage[i_wr_ch] <= i_wr_voltage;
            r_current[i_wr_ch] <= i_wr_current;
        end
    end

    // Read the channel chosen by the frame logic.
    assign o_rd_voltage = r_voltage[i_rd_ch];
    assign o_rd_current = r_current[i_rd_ch];

endmodule

FILE: sv/adc_sfr_frame.sv
// Frame position counter, header capture and reply buffer rebuild at frame end.
module adc_sfr_frame (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_take,
    input  logic [adc_sfr_pkg::BYTE_W-1:0]        i_rx_byte,
    input  adc_sfr_pkg::t_cfg                     i_cfg,
    output logic [adc_sfr_pkg::CH_W-1:0]          o_rd_ch,
    input  logic [adc_sfr_pkg::SAMPLE_W-1:0]      i_rd_voltage,
    input  logic [adc_sfr_pkg::SAMPLE_W-1:0]      i_rd_current,
    output logic [adc_sfr_pkg::BYTE_W-1:0]        o_tx_byte
);

    localparam int BW  = adc_sfr_pkg::BYTE_W;
    localparam int SUM_W = BW + 3;
    localparam logic [adc_sfr_pkg::POS_W-1:0] LAST_POS =
        adc_sfr_pkg::POS_W'(adc_sfr_pkg::FRAME_BYTES - 1);
    localparam logic [adc_sfr_pkg::POS_W-1:0] POS_FRAME =
        adc_sfr_pkg::POS_W'(adc_sfr_pkg::FRAME_BYTES);

    logic [adc_sfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [BW-1:0] r_hdr [2];
    logic [BW-1:0] n_hdr [2];
    logic [BW-1:0] r_reply [adc_sfr_pkg::FRAME_BYTES];
    logic [BW-1:0] n_reply [adc_sfr_pkg::FRAME_BYTES];

    logic [adc_sfr_pkg::CMD_W-1:0]  cmd;
    logic [adc_sfr_pkg::ADDR_W-1:0] adr;
    logic                           cmd_hit;
    logic                           addr_hit;
    logic [adc_sfr_pkg::CH_W-1:0]   hit_ch;
    logic [BW-1:0]                  body [adc_sfr_pkg::FRAME_BYTES-1];
    logic [SUM_W-1:0]               sum;
    logic                           frame_end;

    // Decode the header: command in bits 6:1, address in bits 15:7.
    assign cmd = r_hdr[0][6:1];
    assign adr = {r_hdr[1], r_hdr[0][7]};
    assign cmd_hit = (cmd == i_cfg.ram_read_code);

    // Address slot match, first slot wins.
    always_comb begin
        addr_hit = 1'b1;
        if (adr == i_cfg.addr_slot_a) begin
            hit_ch = adc_sfr_pkg::SLOT_A_CH;
        end else if (adr == i_cfg.addr_slot_b) begin
            hit_ch = adc_sfr_pkg::SLOT_B_CH;
        end else if (adr == i_cfg.addr_slot_c) begin
            hit_ch = adc_sfr_pkg::SLOT_C_CH;
        end else if (adr == i_cfg.addr_slot_d) begin
            hit_ch = adc_sfr_pkg::SLOT_D_CH;
        end else begin
            hit_ch = adc_sfr_pkg::SLOT_D_CH;
            addr_hit = 1'b0;
        end
    end

    assign o_rd_ch = hit_ch;

    // New reply body: header echo, then samples or the old sample bytes.
    always_comb begin
        body[0] = r_hdr[0];
        body[1] = r_hdr[1];
        if (addr_hit) begin
            body[2] = i_rd_voltage[BW-1:0];
            body[3] = i_rd_voltage[2*BW-1:BW];
            body[4] = i_rd_current[BW-1:0];
            body[5] = i_rd_current[2*BW-1:BW];
        end else begin
            body[2] = r_reply[2];
            body[3] = r_reply[3];
            body[4] = r_reply[4];
            body[5] = r_reply[5];
        end
        sum = '0;
        for (int i = 0; i < adc_sfr_pkg::FRAME_BYTES - 1; i++) begin
            sum = sum + SUM_W'(body[i]);
        end
    end

    // Reply byte at the current position, sent bit-reversed.
    assign o_tx_byte = (r_pos < POS_FRAME) ?
        adc_sfr_pkg::flip_bits(r_reply[r_pos]) : '0;

    assign frame_end = (r_pos >= LAST_POS);

    // Next-state logic for position, header and reply.
    always_comb begin
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_reply = r_reply;
        if (i_take) begin
            if (r_pos == 3'd0) begin
                n_hdr[0] = i_rx_byte;
            end
            if (r_pos == 3'd1) begin
                n_hdr[1] = i_rx_byte;
            end
            if (frame_end) begin
                n_pos = '0;
                if (cmd_hit) begin
                    for (int i = 0; i < adc_sfr_pkg::FRAME_BYTES - 1; i++) begin
                        n_reply[i] = body[i];
                    end
                    n_reply[adc_sfr_pkg::FRAME_BYTES-1] = ~sum[BW-1:0];
                end
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr[0] <= '0;
            r_hdr[1] <= '0;
            for (int i = 0; i < adc_sfr_pkg::FRAME_BYTES; i++) begin
                r_reply[i] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_reply <= n_reply;
        end
    end

endmodule

FILE: sv/adc_spi_frame_responder_unit.sv
// Top level of the ADC serial frame responder: configuration, handshake and result register.
// Each result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver does not stall; the frame logic
// and the sample store complete all work between the input handshake and the result register.
// The result register accepts a new item while the held result is taken.
// Reset (synchronous, active low) clears the position, header, reply and
// sample stores to zero and loads the address slots with 0, 1, 2 and 3.
module adc_spi_frame_responder_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic                                     i_operation,
    input  logic [adc_sfr_pkg::BYTE_W-1:0]           i_mosi_byte,
    input  logic [adc_sfr_pkg::CH_W-1:0]             i_channel,
    input  logic signed [adc_sfr_pkg::SAMPLE_W-1:0]  i_voltage_sample,
    input  logic signed [adc_sfr_pkg::SAMPLE_W-1:0]  i_current_sample,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [adc_sfr_pkg::BYTE_W-1:0]           o_miso_byte,
    output logic                                     o_reply_valid,
    input  logic                                     i_cfg_we,
    input  logic [adc_sfr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [adc_sfr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    adc_sfr_pkg::t_cfg r_cfg;
    logic                                  accept;
    logic                                  take_serial;
    logic                                  take_sample;
    logic [adc_sfr_pkg::CH_W-1:0]          rd_ch;
    logic [adc_sfr_pkg::SAMPLE_W-1:0]      rd_voltage;
    logic [adc_sfr_pkg::SAMPLE_W-1:0]      rd_current;
    logic [adc_sfr_pkg::BYTE_W-1:0]        tx_byte;
    logic                                  r_valid;
    logic [adc_sfr_pkg::BYTE_W-1:0]        r_miso;
    logic                                  r_reply_valid;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_read_code <= '0;
            r_cfg.addr_slot_a   <= adc_sfr_pkg::SLOT_A_RST;
            r_cfg.addr_slot_b   <= adc_sfr_pkg::SLOT_B_RST;
            r_cfg.addr_slot_c   <= adc_sfr_pkg::SLOT_C_RST;
            r_cfg.addr_slot_d   <= adc_sfr_pkg::SLOT_D_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adc_sfr_pkg::CFG_RAM_READ_CODE: begin
                    r_cfg.ram_read_code <= i_cfg_data[adc_sfr_pkg::CMD_W-1:0];
                end
                adc_sfr_pkg::CFG_ADDR_SLOT_A: begin
                    r_cfg.addr_slot_a <= i_cfg_data;
                end
                adc_sfr_pkg::CFG_ADDR_SLOT_B: begin
                    r_cfg.addr_slot_b <= i_cfg_data;
                end
                adc_sfr_pkg::CFG_ADDR_SLOT_C: begin
                    r_cfg.addr_slot_c <= i_cfg_data;
                end
                adc_sfr_pkg::CFG_ADDR_SLOT_D: begin
                    r_cfg.addr_slot_d <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input handshake: the result register frees up when its item is taken.
    assign o_stall     = r_valid & i_stall;
    assign accept      = i_valid & ~o_stall;
    assign take_serial = accept & (i_operation == adc_sfr_pkg::OP_SERIAL);
    assign take_sample = accept & (i_operation == adc_sfr_pkg::OP_SAMPLE);

    adc_sfr_samples u_samples (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (take_sample),
        .i_wr_ch      (i_channel),
        .i_wr_voltage (i_voltage_sample),
        .i_wr_current (i_current_sample),
        .i_rd_ch      (rd_ch),
        .o_rd_voltage (rd_voltage),
        .o_rd_current (rd_current)
    );

    adc_sfr_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take_serial),
        .i_rx_byte    (i_mosi_byte),
        .i_cfg        (r_cfg),
        .o_rd_ch      (rd_ch),
        .i_rd_voltage (rd_voltage),
        .i_rd_current (rd_current),
        .o_tx_byte    (tx_byte)
    );

    // Result register: sample items answer with a zero byte and no reply flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_miso        <= take_serial ? tx_byte : '0;
            r_reply_valid <= take_serial;
        end
    end

    assign o_valid       = r_valid;
    assign o_miso_byte   = r_miso;
    assign o_reply_valid = r_reply_valid;

endmodule

FILE: tb/sv/adc_spi_frame_responder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ADC serial frame responder: directed frames, then random traffic.
module adc_spi_frame_responder_unit_tb;

    localparam int BYTE_W     = adc_sfr_pkg::BYTE_W;
    localparam int SAMPLE_W   = adc_sfr_pkg::SAMPLE_W;
    localparam int CMD_W      = adc_sfr_pkg::CMD_W;
    localparam int ADDR_W     = adc_sfr_pkg::ADDR_W;
    localparam int CH_W       = adc_sfr_pkg::CH_W;
    localparam int POS_W      = adc_sfr_pkg::POS_W;
    localparam int CFG_IDX_W  = adc_sfr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = adc_sfr_pkg::CFG_DATA_W;
    localparam int FRAME_BYTES = adc_sfr_pkg::FRAME_BYTES;
    localparam int CHANNELS    = adc_sfr_pkg::CHANNELS;

    localparam int CLK_HALF      = 4;
    localparam int HOLD_CYCLES   = 48;
    localparam int RANDOM_ITEMS  = 584;
    localparam int SETTLE_CYCLES = 3;
    localparam int RAND_PHASES   = 4;

    // One reply as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0] miso;
        logic              reply_valid;
    } t_reply;

    // Receiver stall patterns.
    typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic                       i_operation      = adc_sfr_pkg::OP_SERIAL;
    logic [BYTE_W-1:0]          i_mosi_byte      = '0;
    logic [CH_W-1:0]            i_channel        = '0;
    logic signed [SAMPLE_W-1:0] i_voltage_sample = '0;
    logic signed [SAMPLE_W-1:0] i_current_sample = '0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    logic [BYTE_W-1:0]          o_miso_byte;
    logic                       o_reply_valid;
    logic                       i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data       = '0;

    adc_spi_frame_responder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_mosi_byte      (i_mosi_byte),
        .i_channel        (i_channel),
        .i_voltage_sample (i_voltage_sample),
        .i_current_sample (i_current_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_miso_byte      (o_miso_byte),
        .o_reply_valid    (o_reply_valid),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("** adc_spi_frame_responder_unit: FAILED **");
        $finish;
    end

    // Mirror of the responder state and its registers.
    logic [POS_W-1:0]    frame_pos;
    logic [BYTE_W-1:0]   hdr_byte [2];
    logic [BYTE_W-1:0]   reply_byte [FRAME_BYTES];
    logic [SAMPLE_W-1:0] volt_mem [CHANNELS];
    logic [SAMPLE_W-1:0] curr_mem [CHANNELS];
    logic [CMD_W-1:0]    read_code;
    logic [ADDR_W-1:0]   slot_addr [4];

    t_reply expected_replies [$];
    int     errors = 0;

    // Sender bookkeeping.
    int tx_pos      = 0;
    int items_sent  = 0;
    bit valid_up    = 1'b0;
    bit no_gaps     = 1'b0;
    int burst_left  = 0;

    // Long receiver hold-off requests.
    int hold_req  = 0;
    int hold_seen = 0;

    function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] b);
        return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
    endfunction

    function automatic void reset_model();
        frame_pos   = '0;
        hdr_byte[0] = '0;
        hdr_byte[1] = '0;
        for (int i = 0; i < FRAME_BYTES; i++) reply_byte[i] = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            volt_mem[i] = '0;
            curr_mem[i] = '0;
        end
        read_code    = '0;
        slot_addr[0] = adc_sfr_pkg::SLOT_A_RST;
        slot_addr[1] = adc_sfr_pkg::SLOT_B_RST;
        slot_addr[2] = adc_sfr_pkg::SLOT_C_RST;
        slot_addr[3] = adc_sfr_pkg::SLOT_D_RST;
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            adc_sfr_pkg::CFG_RAM_READ_CODE: read_code    = data[CMD_W-1:0];
            adc_sfr_pkg::CFG_ADDR_SLOT_A:   slot_addr[0] = data[ADDR_W-1:0];
            adc_sfr_pkg::CFG_ADDR_SLOT_B:   slot_addr[1] = data[ADDR_W-1:0];
            adc_sfr_pkg::CFG_ADDR_SLOT_C:   slot_addr[2] = data[ADDR_W-1:0];
            adc_sfr_pkg::CFG_ADDR_SLOT_D:   slot_addr[3] = data[ADDR_W-1:0];
            default: ;
        endcase
    endfunction

    // Frame end: rebuild the reply from the captured header on a RAM-read command.
    function automatic void rebuild_reply();
        logic [2*BYTE_W-1:0] hdr16;
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   adr;
        logic [BYTE_W-1:0]   sum;
        logic [CH_W-1:0]     ch;
        logic                hit;
        hdr16 = {hdr_byte[1], hdr_byte[0]};
        cmd   = hdr16[6:1];
        adr   = hdr16[15:7];
        if (cmd != read_code) return;
        reply_byte[0] = hdr_byte[0];
        reply_byte[1] = hdr_byte[1];
        hit = 1'b1;
        ch  = adc_sfr_pkg::SLOT_D_CH;
        // The first matching slot wins, in the order a, b, c, d.
        if (adr == slot_addr[0]) ch = adc_sfr_pkg::SLOT_A_CH;
        else if (adr == slot_addr[1]) ch = adc_sfr_pkg::SLOT_B_CH;
        else if (adr == slot_addr[2]) ch = adc_sfr_pkg::SLOT_C_CH;
        else if (adr == slot_addr[3]) ch = adc_sfr_pkg::SLOT_D_CH;
        else hit = 1'b0;
        if (hit) begin
            reply_byte[2] = volt_mem[ch][7:0];
            reply_byte[3] = volt_mem[ch][15:8];
            reply_byte[4] = curr_mem[ch][7:0];
            reply_byte[5] = curr_mem[ch][15:8];
        end
        sum = '0;
        for (int i = 0; i < 6; i++) sum += reply_byte[i];
        reply_byte[FRAME_BYTES-1] = ~sum;
    endfunction

    // Expected reply for one accepted item; updates the mirrored state.
    function automatic t_reply predict_reply(input logic op, input logic [BYTE_W-1:0] rx,
                                             input logic [CH_W-1:0] ch,
                                             input logic [SAMPLE_W-1:0] v,
                                             input logic [SAMPLE_W-1:0] c);
        t_reply r;
        if (op == adc_sfr_pkg::OP_SAMPLE) begin
            volt_mem[ch]  = v;
            curr_mem[ch]  = c;
            r.miso        = '0;
            r.reply_valid = 1'b0;
            return r;
        end
        r.miso        = mirror_byte(reply_byte[frame_pos]);
        r.reply_valid = 1'b1;
        if (frame_pos < 2) hdr_byte[frame_pos[0]] = rx;
        if (frame_pos == FRAME_BYTES - 1) begin
            frame_pos = '0;
            rebuild_reply();
        end else begin
            frame_pos = frame_pos + 1'b1;
        end
        return r;
    endfunction

    // Predict on every accepted item and check every accepted reply.
    always @(posedge i_clk) begin : reply_checker
        t_reply want;
        if (!i_rst_n) begin
            reset_model();
            expected_replies.delete();
        end else begin
            if (i_cfg_we) load_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                expected_replies.push_back(predict_reply(i_operation, i_mosi_byte, i_channel,
                                                         i_voltage_sample, i_current_sample));
            end
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected reply, expected none, actual %02h / %0b",
                             $time, o_miso_byte, o_reply_valid);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_miso_byte !== want.miso) begin
                        errors++;
                        $display("%0t: miso_byte mismatch, expected %02h, actual %02h",
                                 $time, want.miso, o_miso_byte);
                    end
                    if (o_reply_valid !== want.reply_valid) begin
                        errors++;
                        $display("%0t: reply_valid mismatch, expected %0b, actual %0b",
                                 $time, want.reply_valid, o_reply_valid);
                    end
                end
            end
        end
    end

    // Receiver: changing stall patterns, with long hold-offs on request.
    initial begin : rx_pacing
        t_rx_mode mode;
        int       seg_left;
        int       step;
        int       hold_left;
        mode      = RX_FREE;
        seg_left  = 0;
        step      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(16, 96);
                    step     = 0;
                end
                seg_left--;
                step++;
                case (mode)
                    RX_FREE:     i_stall <= 1'b0;
                    RX_COIN:     i_stall <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: i_stall <= (step % 4 == 3);
                    default:     i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Sender pacing: bursts of random length with random gaps between them.
    task automatic pace_sender();
        int gap;
        if (no_gaps) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Offer one item and wait until the block takes it.
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] rx,
                             input logic [CH_W-1:0] ch,
                             input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c);
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_mosi_byte      <= rx;
        i_channel        <= ch;
        i_voltage_sample <= v;
        i_current_sample <= c;
        valid_up = 1'b1;
        items_sent++;
        if (op == adc_sfr_pkg::OP_SERIAL) tx_pos = (tx_pos + 1) % FRAME_BYTES;
        do @(posedge i_clk); while (o_stall);
        pace_sender();
    endtask

    task automatic send_serial(input logic [BYTE_W-1:0] rx);
        send_item(adc_sfr_pkg::OP_SERIAL, rx, CH_W'($urandom_range(0, 3)),
                  SAMPLE_W'($urandom_range(0, 16'hFFFF)),
                  SAMPLE_W'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] v,
                               input logic [SAMPLE_W-1:0] c);
        send_item(adc_sfr_pkg::OP_SAMPLE, BYTE_W'($urandom_range(0, 255)), ch, v, c);
    endtask

    // Sample value biased toward the extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic send_random_sample();
        send_sample(CH_W'($urandom_range(0, 3)), pick_sample(), pick_sample());
    endtask

    // Align to a frame boundary, then send one whole frame with the given header.
    task automatic send_frame(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] adr,
                              input bit mix_samples);
        logic [2*BYTE_W-1:0] hdr16;
        hdr16 = {adr, cmd, 1'($urandom_range(0, 1))};
        while (tx_pos != 0) send_serial(BYTE_W'($urandom_range(0, 255)));
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (mix_samples && $urandom_range(0, 5) == 0) send_random_sample();
            if (i == 0) send_serial(hdr16[7:0]);
            else if (i == 1) send_serial(hdr16[15:8]);
            else send_serial(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Stop offering items and wait until every reply has come back.
    task automatic drain();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] code,
                              input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                              input logic [ADDR_W-1:0] c, input logic [ADDR_W-1:0] d);
        drain();
        write_reg(adc_sfr_pkg::CFG_RAM_READ_CODE, code);
        write_reg(adc_sfr_pkg::CFG_ADDR_SLOT_A, a);
        write_reg(adc_sfr_pkg::CFG_ADDR_SLOT_B, b);
        write_reg(adc_sfr_pkg::CFG_ADDR_SLOT_C, c);
        write_reg(adc_sfr_pkg::CFG_ADDR_SLOT_D, d);
    endtask

    // A read with the reset settings: command zero, address zero selects channel 1.
    task automatic test_reset_defaults();
        send_frame(6'd0, adc_sfr_pkg::SLOT_A_RST, 1'b0);
    endtask

    // Extreme samples on channels 0 to 2 and a pattern on channel 3, then read one of them back.
    task automatic test_sample_extremes();
        send_sample(2'd0, 16'h8000, 16'h7FFF);
        send_sample(2'd1, 16'h7FFF, 16'h8000);
        send_sample(2'd2, 16'hFFFF, 16'h0000);
        send_sample(2'd3, 16'h5A5A, 16'hA5A5);
        send_frame(6'd0, adc_sfr_pkg::SLOT_A_RST, 1'b0);
    endtask

    // A command other than the read code leaves the reply as it was.
    task automatic test_other_command();
        send_frame(6'h3F, 9'h1FF, 1'b0);
    endtask

    // An address that no slot holds keeps the old sample bytes.
    task automatic test_unmatched_address();
        send_frame(6'd0, 9'd300, 1'b0);
    endtask

    // All slots equal: slot a wins. Wide write data and unknown indexes are ignored.
    task automatic test_equal_slots();
        set_config(9'h1C5, 9'd9, 9'd9, 9'd9, 9'd9);
        write_reg(3'd5, 9'h1FF);
        write_reg(3'd7, 9'h0AA);
        send_frame(6'd5, 9'd9, 1'b0);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_receiver_holdoff();
        no_gaps = 1'b1;
        hold_req <= hold_req + 1;
        repeat (3) send_frame(read_code, slot_addr[2'($urandom_range(0, 3))], 1'b1);
        no_gaps = 1'b0;
    endtask

    // Random traffic over several register settings; mostly whole frames.
    task automatic test_random_phases();
        int target;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: set_config(CFG_DATA_W'($urandom_range(0, 63)),
                              ADDR_W'($urandom_range(0, 511)),
                              ADDR_W'($urandom_range(0, 511)),
                              ADDR_W'($urandom_range(0, 511)),
                              ADDR_W'($urandom_range(0, 511)));
                1: set_config(9'd63, 9'd511, 9'd0, 9'd511, 9'd256);
                2: set_config(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
                default: set_config(CFG_DATA_W'($urandom_range(0, 63)),
                                    9'd1, 9'd2, 9'd3, 9'd4);
            endcase
            no_gaps = (ph == 1);
            target  = items_sent + RANDOM_ITEMS / RAND_PHASES;
            while (items_sent < target) begin
                case ($urandom_range(0, 9))
                    7: repeat ($urandom_range(1, 3)) send_serial(BYTE_W'($urandom_range(0, 255)));
                    8: send_random_sample();
                    9: begin
                        // Broken frame: a header and a few bytes, then the next frame
                        // realigns with filler.
                        send_serial(BYTE_W'($urandom_range(0, 255)));
                        repeat ($urandom_range(0, 4)) send_serial(BYTE_W'($urandom_range(0, 255)));
                    end
                    default: send_frame(($urandom_range(0, 3) != 0) ? read_code
                                            : CMD_W'($urandom_range(0, 63)),
                                        ($urandom_range(0, 1) != 0)
                                            ? slot_addr[2'($urandom_range(0, 3))]
                                            : ADDR_W'($urandom_range(0, 511)),
                                        1'b1);
                endcase
            end
            no_gaps = 1'b0;
        end
    endtask

    // Reset, then run the tests in turn and report.
    initial begin : test_sequence
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_sample_extremes();
        test_other_command();
        test_unmatched_address();
        test_equal_slots();
        test_receiver_holdoff();
        test_random_phases();
        drain();
        if (errors == 0) begin
            $display("** adc_spi_frame_responder_unit: PASSED **");
        end else begin
            $display("** adc_spi_frame_responder_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/adc_sfr_pkg.sv
sv/adc_sfr_samples.sv
sv/adc_sfr_frame.sv
sv/adc_spi_frame_responder_unit.sv
tb/sv/adc_spi_frame_responder_unit_tb.sv
